/* sv/ac3hp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser package
// Shared types, status codes and decode tables of the sync frame header parser.
// ----------------------------------------------------------------------------
package ac3hp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h0B;
    localparam logic [7:0] SYNC_SECOND = 8'h77;

    // Number of header bytes after the sync word that are kept for decoding
    // (bytes 2 to 6); byte 7 only closes the header.
    localparam int HDR_KEEP = 5;
    localparam logic [2:0] POS_LAST = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_BSID   = 3'd1;
    localparam logic [2:0] ST_BAD_RATE   = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
    localparam logic [2:0] ST_TOO_SMALL  = 3'd5;

    localparam logic [1:0] FTYPE_AC3     = 2'd2;
    localparam logic [1:0] FTYPE_RESV    = 2'd3;
    localparam logic [1:0] FSCOD_RESV    = 2'd3;
    localparam logic [1:0] BLOCKS_SIX    = 2'd3;

    localparam logic [4:0] BSID_AC3_MAX  = 5'd10;
    localparam logic [4:0] BSID_EAC3_MAX = 5'd16;
    localparam logic [5:0] FSC_MAX       = 6'd37;
    localparam logic [12:0] EAC3_MIN_BYTES = 13'd7;

    typedef struct packed {
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
    } hdr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        enhanced;
        logic [4:0]  bitstream_id;
        logic [1:0]  frame_kind;
        logic [12:0] frame_bytes;
        logic [15:0] rate_hz;
        logic [2:0]  coding_mode;
        logic        lfe_present;
        logic [2:0]  channel_count;
        logic [1:0]  blocks_code;
    } result_t;

    typedef struct packed {
        logic hdr_valid;
    } stage_ctl_t;

    // Nominal bit rate in kbit/s for each pair of frame size codes. The 48 kHz
    // frame holds twice this many words and the 32 kHz frame three times.
    function automatic logic [9:0] ac3_kbps(input logic [4:0] idx);
        logic [9:0] k;
        begin
            case (idx)
                5'd0:    k = 10'd32;
                5'd1:    k = 10'd40;
                5'd2:    k = 10'd48;
                5'd3:    k = 10'd56;
                5'd4:    k = 10'd64;
                5'd5:    k = 10'd80;
                5'd6:    k = 10'd96;
                5'd7:    k = 10'd112;
                5'd8:    k = 10'd128;
                5'd9:    k = 10'd160;
                5'd10:   k = 10'd192;
                5'd11:   k = 10'd224;
                5'd12:   k = 10'd256;
                5'd13:   k = 10'd320;
                5'd14:   k = 10'd384;
                5'd15:   k = 10'd448;
                5'd16:   k = 10'd512;
                5'd17:   k = 10'd576;
                5'd18:   k = 10'd640;
                default: k = 10'd0;
            endcase
            return k;
        end
    endfunction

    // Words in a 44.1 kHz frame for the even code of each pair; the odd code
    // carries one padding word more.
    function automatic logic [10:0] ac3_words44(input logic [4:0] idx);
        logic [10:0] w;
        begin
            case (idx)
                5'd0:    w = 11'd69;
                5'd1:    w = 11'd87;
                5'd2:    w = 11'd104;
                5'd3:    w = 11'd121;
                5'd4:    w = 11'd139;
                5'd5:    w = 11'd174;
                5'd6:    w = 11'd208;
                5'd7:    w = 11'd243;
                5'd8:    w = 11'd278;
                5'd9:    w = 11'd348;
                5'd10:   w = 11'd417;
                5'd11:   w = 11'd487;
                5'd12:   w = 11'd557;
                5'd13:   w = 11'd696;
                5'd14:   w = 11'd835;
                5'd15:   w = 11'd975;
                5'd16:   w = 11'd1114;
                5'd17:   w = 11'd1253;
                5'd18:   w = 11'd1393;
                default: w = 11'd0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [15:0] base_rate(input logic [1:0] code);
        logic [15:0] r;
        begin
            case (code)
                2'd0:    r = 16'd48000;
                2'd1:    r = 16'd44100;
                2'd2:    r = 16'd32000;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] mode_chans(input logic [2:0] acmod);
        logic [2:0] c;
        begin
            case (acmod)
                3'd0:    c = 3'd2;
                3'd1:    c = 3'd1;
                3'd2:    c = 3'd2;
                3'd3:    c = 3'd3;
                3'd4:    c = 3'd3;
                3'd5:    c = 3'd4;
                3'd6:    c = 3'd4;
                default: c = 3'd5;
            endcase
            return c;
        end
    endfunction

endpackage

/* sv/ac3hp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser channel interfaces
// Byte stream channel and decoded header channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface ac3hp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_last;

    modport source (output valid, output data_byte, output packet_last, input ready);
    modport sink   (input valid, input data_byte, input packet_last, output ready);
endinterface

interface ac3hp_hdr_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        enhanced;
    logic [4:0]  bitstream_id;
    logic [1:0]  frame_kind;
    logic [12:0] frame_bytes;
    logic [15:0] rate_hz;
    logic [2:0]  coding_mode;
    logic        lfe_present;
    logic [2:0]  channel_count;
    logic [1:0]  blocks_code;

    modport source (
        output valid, output status, output enhanced, output bitstream_id,
        output frame_kind, output frame_bytes, output rate_hz,
        output coding_mode, output lfe_present, output channel_count,
        output blocks_code, input ready
    );
    modport sink (
        input valid, input status, input enhanced, input bitstream_id,
        input frame_kind, input frame_bytes, input rate_hz,
        input coding_mode, input lfe_present, input channel_count,
        input blocks_code, output ready
    );
endinterface

/* sv/ac3hp_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser: sync hunt and header capture
// Finds the sync word, collects the header bytes and hands a complete header
// to the decode stage through the header register.
// ----------------------------------------------------------------------------
module ac3hp_capture (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              data_byte,
    input  logic                    packet_last,
    input  logic                    advance,
    output ac3hp_pkg::stage_ctl_t   ctl,
    output ac3hp_pkg::hdr_t         hdr
);
    import ac3hp_pkg::*;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        COLLECT
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic       hdr_valid_reg, hdr_valid_next;
    logic       accept;
    logic       complete;
    logic       store_wr;

    logic [7:0] coll_reg [HDR_KEEP];
    hdr_t       hdr_reg;

    // A byte is refused only while a finished header still waits for the
    // decode stage to move on.
    assign in_ready = !hdr_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        complete   = 1'b0;
        store_wr   = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                SEEK_SECOND:
                begin
                    if (data_byte == SYNC_SECOND)
                    begin
                        phase_next = COLLECT;
                        pos_next   = 3'd0;
                    end
                    else if (data_byte != SYNC_FIRST)
                    begin
                        phase_next = SEEK_FIRST;
                    end
                end
                COLLECT:
                begin
                    store_wr = (pos_reg < POS_LAST);
                    if (pos_reg == POS_LAST)
                    begin
                        complete   = 1'b1;
                        phase_next = SEEK_FIRST;
                        pos_next   = 3'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = (data_byte == SYNC_FIRST) ? SEEK_SECOND : SEEK_FIRST;
                end
            endcase
            // The current byte is handled first; a packet end then drops any
            // partial header.
            if (packet_last)
            begin
                phase_next = SEEK_FIRST;
                pos_next   = 3'd0;
            end
        end

        if (complete)
            hdr_valid_next = 1'b1;
        else if (advance)
            hdr_valid_next = 1'b0;
        else
            hdr_valid_next = hdr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= SEEK_FIRST;
            pos_reg       <= 3'd0;
            hdr_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hdr_valid_reg <= hdr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
            coll_reg[pos_reg] <= data_byte;
        if (complete)
            hdr_reg <= '{b2: coll_reg[0], b3: coll_reg[1], b4: coll_reg[2],
                         b5: coll_reg[3], b6: coll_reg[4]};
    end

    assign ctl.hdr_valid = hdr_valid_reg;
    assign hdr           = hdr_reg;

endmodule

/* sv/ac3hp_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser: header decode and result register
// Decodes the captured header bytes along the AC-3 or E-AC-3 path and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module ac3hp_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ac3hp_pkg::stage_ctl_t   ctl,
    input  ac3hp_pkg::hdr_t         hdr,
    output logic                    advance,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ac3hp_pkg::result_t      result
);
    import ac3hp_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    result_reg, result_next;

    logic [4:0]  bsid;
    logic [1:0]  fscod;
    logic [5:0]  fsc;
    logic [1:0]  sub;
    logic [9:0]  kbps;
    logic [10:0] words;
    logic [1:0]  shift;
    logic [2:0]  acmod;
    logic        lfe;
    logic [1:0]  ftype;
    logic [12:0] fbytes;
    logic [15:0] rate;
    logic [1:0]  blocks;
    logic [2:0]  status;
    logic        enh;

    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        bsid   = hdr.b5[7:3];
        fscod  = hdr.b4[7:6];
        fsc    = hdr.b4[5:0];
        sub    = hdr.b4[5:4];
        kbps   = ac3_kbps(fsc[5:1]);
        status = ST_OK;
        enh    = 1'b0;
        ftype  = 2'd0;
        fbytes = 13'd0;
        rate   = 16'd0;
        acmod  = 3'd0;
        lfe    = 1'b0;
        blocks = 2'd0;
        words  = 11'd0;
        shift  = 2'd0;

        if (bsid > BSID_EAC3_MAX)
        begin
            status = ST_BAD_BSID;
        end
        else if (bsid <= BSID_AC3_MAX)
        begin
            if (fscod == FSCOD_RESV)
                status = ST_BAD_RATE;
            else if (fsc > FSC_MAX)
                status = ST_BAD_SIZE;
            else
            begin
                case (fscod)
                    2'd0:    words = {kbps, 1'b0};
                    2'd1:    words = ac3_words44(fsc[5:1]) + {10'd0, fsc[0]};
                    default: words = {kbps, 1'b0} + {1'b0, kbps};
                endcase
                // Half and quarter rate streams signal themselves by bsid.
                case (bsid)
                    5'd9:    shift = 2'd1;
                    5'd10:   shift = 2'd2;
                    default: shift = 2'd0;
                endcase
                acmod = hdr.b6[7:5];
                // The LFE flag moves down past the mix level and surround
                // fields that the coding mode carries.
                case (acmod)
                    3'd2, 3'd3, 3'd4: lfe = hdr.b6[2];
                    3'd5, 3'd6, 3'd7: lfe = (acmod == 3'd6) ? hdr.b6[2] : hdr.b6[0];
                    default:          lfe = hdr.b6[4];
                endcase
                rate   = base_rate(fscod) >> shift;
                fbytes = {1'b0, words, 1'b0};
                ftype  = FTYPE_AC3;
                blocks = BLOCKS_SIX;
            end
        end
        else
        begin
            enh    = 1'b1;
            ftype  = hdr.b2[7:6];
            fbytes = {({1'b0, hdr.b2[2:0], hdr.b3} + 12'd1), 1'b0};
            if (ftype == FTYPE_RESV)
                status = ST_BAD_TYPE;
            else if (fbytes < EAC3_MIN_BYTES)
                status = ST_TOO_SMALL;
            else
            begin
                if (fscod == FSCOD_RESV)
                begin
                    if (sub == FSCOD_RESV)
                        status = ST_BAD_RATE;
                    else
                    begin
                        rate   = base_rate(sub) >> 1;
                        blocks = BLOCKS_SIX;
                    end
                end
                else
                begin
                    rate   = base_rate(fscod);
                    blocks = sub;
                end
                acmod = hdr.b4[3:1];
                lfe   = hdr.b4[0];
            end
        end

        result_next.status       = status;
        result_next.enhanced     = enh;
        result_next.bitstream_id = bsid;
        if (status != ST_OK)
        begin
            result_next.frame_kind    = 2'd0;
            result_next.frame_bytes   = 13'd0;
            result_next.rate_hz       = 16'd0;
            result_next.coding_mode   = 3'd0;
            result_next.lfe_present   = 1'b0;
            result_next.channel_count = 3'd0;
            result_next.blocks_code   = 2'd0;
        end
        else
        begin
            result_next.frame_kind    = ftype;
            result_next.frame_bytes   = fbytes;
            result_next.rate_hz       = rate;
            result_next.coding_mode   = acmod;
            result_next.lfe_present   = lfe;
            result_next.channel_count = mode_chans(acmod) + {2'd0, lfe};
            result_next.blocks_code   = blocks;
        end

        if (ctl.hdr_valid && advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hdr_valid && advance)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

/* sv/ac3_eac3_header_parser.sv */
`timescale 1ns / 1ps
// Output path: the header register, then the result register.
// Throughput: one byte per cycle; a new byte is taken while a result waits,
// and input stalls only when a second finished header meets a stalled result.
// Each header needs eight byte transfers, sync word included.
// Reset: rst_n, asynchronous and active low, returns the hunt to the first
// sync byte and empties both the header register and the result register.
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 sync frame header parser
// Hunts for the sync word in a byte stream and decodes each complete header.
// ----------------------------------------------------------------------------
module ac3_eac3_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    ac3hp_byte_if.sink  stream,
    ac3hp_hdr_if.source header
);
    import ac3hp_pkg::*;

    stage_ctl_t ctl;
    hdr_t       hdr;
    result_t    result;
    logic       advance;

    ac3hp_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stream.valid),
        .in_ready    (stream.ready),
        .data_byte   (stream.data_byte),
        .packet_last (stream.packet_last),
        .advance     (advance),
        .ctl         (ctl),
        .hdr         (hdr)
    );

    ac3hp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hdr       (hdr),
        .advance   (advance),
        .out_valid (header.valid),
        .out_ready (header.ready),
        .result    (result)
    );

    assign header.status        = result.status;
    assign header.enhanced      = result.enhanced;
    assign header.bitstream_id  = result.bitstream_id;
    assign header.frame_kind    = result.frame_kind;
    assign header.frame_bytes   = result.frame_bytes;
    assign header.rate_hz       = result.rate_hz;
    assign header.coding_mode   = result.coding_mode;
    assign header.lfe_present   = result.lfe_present;
    assign header.channel_count = result.channel_count;
    assign header.blocks_code   = result.blocks_code;

endmodule

/* sv/ac3hp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser checker
// Port-level checks on header results, bound to the top level.
// ----------------------------------------------------------------------------
module ac3hp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        enhanced,
    input logic [4:0]  bitstream_id,
    input logic [1:0]  frame_kind,
    input logic [12:0] frame_bytes,
    input logic [15:0] rate_hz,
    input logic [1:0]  blocks_code
);
    import ac3hp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_bytes))
        else $error("header result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> frame_bytes == 13'd0 && rate_hz == 16'd0)
        else $error("error result carries a length or rate");

    a_enh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> enhanced == (bitstream_id > BSID_AC3_MAX && bitstream_id <= BSID_EAC3_MAX))
        else $error("enhanced flag does not follow bsid");

    a_ac3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && !enhanced |->
            frame_kind == FTYPE_AC3 && blocks_code == BLOCKS_SIX)
        else $error("AC-3 result has wrong frame type or blocks code");

    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("header result appeared without a closing byte transfer");

endmodule

bind ac3_eac3_header_parser ac3hp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (stream.valid),
    .in_ready     (stream.ready),
    .out_valid    (header.valid),
    .out_ready    (header.ready),
    .status       (header.status),
    .enhanced     (header.enhanced),
    .bitstream_id (header.bitstream_id),
    .frame_kind   (header.frame_kind),
    .frame_bytes  (header.frame_bytes),
    .rate_hz      (header.rate_hz),
    .blocks_code  (header.blocks_code)
);

/* dv/tb_ac3_eac3_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 header parser testbench
// Streams sync frames, broken sync words, packet ends and noise into the
// parser. Expected headers are decoded independently and compared, in order
// and field by field, with every header transfer taken from the output.
// ----------------------------------------------------------------------------
module tb_ac3_eac3_header_parser;

    import ac3hp_pkg::*;

    localparam int    NO_END        = -1;
    localparam int    RANDOM_BYTES  = 1320;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    DRAIN_CYCLES  = 20;
    localparam int    MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS   = 2_000_000;

    typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, HUNT_COLLECT} hunt_e;

    class hdr_scoreboard;
        hunt_e       phase;
        logic [7:0]  hdr_bytes [6];
        int unsigned pos_idx;
        result_t     expected_hdrs [$];
        int unsigned err_count;

        function new();
            phase     = HUNT_FIRST;
            pos_idx   = 0;
            err_count = 0;
        endfunction

        function int unsigned pending();
            return expected_hdrs.size();
        endfunction

        function int unsigned base_hz(input logic [1:0] code);
            case (code)
                2'd0:    return 48000;
                2'd1:    return 44100;
                default: return 32000;
            endcase
        endfunction

        function int unsigned full_band_chans(input logic [2:0] acmod);
            case (acmod)
                3'd0:    return 2;
                3'd1:    return 1;
                3'd2:    return 2;
                3'd3:    return 3;
                3'd4:    return 3;
                3'd5:    return 4;
                3'd6:    return 4;
                default: return 5;
            endcase
        endfunction

        // 16-bit words in an AC-3 frame. The 48 kHz and 32 kHz columns follow
        // from the bit rate; the 44.1 kHz column pads the odd code by one word.
        function int unsigned frame_words(input logic [5:0] fsc, input logic [1:0] fscod);
            int unsigned kbps;
            int unsigned w44;
            case (fsc[5:1])
                5'd0:    begin kbps = 32;  w44 = 69;   end
                5'd1:    begin kbps = 40;  w44 = 87;   end
                5'd2:    begin kbps = 48;  w44 = 104;  end
                5'd3:    begin kbps = 56;  w44 = 121;  end
                5'd4:    begin kbps = 64;  w44 = 139;  end
                5'd5:    begin kbps = 80;  w44 = 174;  end
                5'd6:    begin kbps = 96;  w44 = 208;  end
                5'd7:    begin kbps = 112; w44 = 243;  end
                5'd8:    begin kbps = 128; w44 = 278;  end
                5'd9:    begin kbps = 160; w44 = 348;  end
                5'd10:   begin kbps = 192; w44 = 417;  end
                5'd11:   begin kbps = 224; w44 = 487;  end
                5'd12:   begin kbps = 256; w44 = 557;  end
                5'd13:   begin kbps = 320; w44 = 696;  end
                5'd14:   begin kbps = 384; w44 = 835;  end
                5'd15:   begin kbps = 448; w44 = 975;  end
                5'd16:   begin kbps = 512; w44 = 1114; end
                5'd17:   begin kbps = 576; w44 = 1253; end
                default: begin kbps = 640; w44 = 1393; end
            endcase
            case (fscod)
                2'd0:    return 2 * kbps;
                2'd1:    return w44 + fsc[0];
                default: return 3 * kbps;
            endcase
        endfunction

        function result_t decode_header();
            result_t      r;
            logic [4:0]   bsid;
            logic [1:0]   fscod;
            logic [1:0]   sub;
            logic [5:0]   fsc;
            logic [2:0]   acmod;
            logic [10:0]  frmsiz;
            int unsigned  skip;
            int unsigned  shift;
            r     = '0;
            bsid  = hdr_bytes[3][7:3];
            fscod = hdr_bytes[2][7:6];
            r.bitstream_id = bsid;
            if (bsid > BSID_EAC3_MAX) begin
                r.status = ST_BAD_BSID;
            end
            else if (bsid <= BSID_AC3_MAX) begin
                fsc = hdr_bytes[2][5:0];
                if (fscod == FSCOD_RESV) begin
                    r.status = ST_BAD_RATE;
                end
                else if (fsc > FSC_MAX) begin
                    r.status = ST_BAD_SIZE;
                end
                else begin
                    acmod = hdr_bytes[4][7:5];
                    skip  = 0;
                    if (acmod == 3'd2) begin
                        skip = 2;
                    end
                    else begin
                        if (acmod[0] && acmod != 3'd1) skip = 2;
                        if (acmod[2]) skip += 2;
                    end
                    // The LFE flag follows the three coding mode bits of byte 6 and the optional
                    // mix level fields.
                    r.lfe_present  = hdr_bytes[4][4 - skip];
                    r.coding_mode  = acmod;
                    shift          = (bsid > 5'd8) ? bsid - 8 : 0;
                    r.rate_hz      = 16'(base_hz(fscod) >> shift);
                    r.frame_bytes  = 13'(2 * frame_words(fsc, fscod));
                    r.frame_kind   = FTYPE_AC3;
                    r.blocks_code  = BLOCKS_SIX;
                end
            end
            else begin
                r.enhanced   = 1'b1;
                r.frame_kind = hdr_bytes[0][7:6];
                frmsiz       = {hdr_bytes[0][2:0], hdr_bytes[1]};
                r.frame_bytes = (frmsiz + 13'd1) << 1;
                sub          = hdr_bytes[2][5:4];
                if (r.frame_kind == FTYPE_RESV) begin
                    r.status = ST_BAD_TYPE;
                end
                else if (r.frame_bytes < EAC3_MIN_BYTES) begin
                    r.status = ST_TOO_SMALL;
                end
                else begin
                    if (fscod == FSCOD_RESV) begin
                        if (sub == FSCOD_RESV) begin
                            r.status = ST_BAD_RATE;
                        end
                        else begin
                            r.rate_hz     = 16'(base_hz(sub) / 2);
                            r.blocks_code = BLOCKS_SIX;
                        end
                    end
                    else begin
                        r.rate_hz     = 16'(base_hz(fscod));
                        r.blocks_code = sub;
                    end
                    r.coding_mode  = hdr_bytes[2][3:1];
                    r.lfe_present  = hdr_bytes[2][0];
                end
            end
            if (r.status != ST_OK) begin
                r.frame_kind   = '0;
                r.frame_bytes  = '0;
                r.rate_hz      = '0;
                r.coding_mode  = '0;
                r.lfe_present  = '0;
                r.blocks_code  = '0;
            end
            else begin
                r.channel_count = 3'(full_band_chans(r.coding_mode) + r.lfe_present);
            end
            return r;
        endfunction

        function void note_byte(input logic [7:0] b, input logic pkt_end);
            case (phase)
                HUNT_SECOND:
                begin
                    if (b == SYNC_SECOND) begin
                        phase   = HUNT_COLLECT;
                        pos_idx = 0;
                    end
                    else if (b != SYNC_FIRST) begin
                        phase = HUNT_FIRST;
                    end
                end
                HUNT_COLLECT:
                begin
                    hdr_bytes[pos_idx] = b;
                    if (pos_idx == 5) begin
                        expected_hdrs.push_back(decode_header());
                        phase   = HUNT_FIRST;
                        pos_idx = 0;
                    end
                    else begin
                        pos_idx++;
                    end
                end
                default:
                begin
                    phase = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
                end
            endcase
            // The byte that carries the packet end is handled first.
            if (pkt_end) begin
                phase   = HUNT_FIRST;
                pos_idx = 0;
            end
        endfunction

        function string fmt(input result_t r);
            return $sformatf({"st=%0d enh=%0d bsid=%0d type=%0d bytes=%0d rate=%0d ",
                              "acmod=%0d lfe=%0d ch=%0d blk=%0d"},
                             r.status, r.enhanced, r.bitstream_id, r.frame_kind,
                             r.frame_bytes, r.rate_hz, r.coding_mode,
                             r.lfe_present, r.channel_count, r.blocks_code);
        endfunction

        function void check_header(input result_t got);
            result_t exp;
            bit      same;
            if (expected_hdrs.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("ERROR: header with none expected: %s", fmt(got));
                return;
            end
            exp  = expected_hdrs.pop_front();
            same = (got.status === exp.status) && (got.enhanced === exp.enhanced) &&
                   (got.bitstream_id === exp.bitstream_id) &&
                   (got.frame_kind === exp.frame_kind) &&
                   (got.frame_bytes === exp.frame_bytes) &&
                   (got.rate_hz === exp.rate_hz) &&
                   (got.coding_mode === exp.coding_mode) &&
                   (got.lfe_present === exp.lfe_present) &&
                   (got.channel_count === exp.channel_count) &&
                   (got.blocks_code === exp.blocks_code);
            if (!same) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("ERROR: header mismatch at %0t", $realtime);
                    $display("  expected %s", fmt(exp));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ac3hp_byte_if stream_if ();
    ac3hp_hdr_if  header_if ();

    ac3_eac3_header_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .header (header_if)
    );

    hdr_scoreboard sb;
    int unsigned   bytes_sent;
    int unsigned   tx_idle_pct;
    int unsigned   rx_idle_pct;
    bit            hold_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin : header_sink
        int unsigned hold_left;
        hold_left = 0;
        header_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                header_if.ready <= 1'b0;
            end
            else begin
                header_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : header_monitor
        result_t got;
        if (rst_n === 1'b1 && header_if.valid === 1'b1 && header_if.ready === 1'b1) begin
            got.status        = header_if.status;
            got.enhanced      = header_if.enhanced;
            got.bitstream_id  = header_if.bitstream_id;
            got.frame_kind    = header_if.frame_kind;
            got.frame_bytes   = header_if.frame_bytes;
            got.rate_hz       = header_if.rate_hz;
            got.coding_mode   = header_if.coding_mode;
            got.lfe_present   = header_if.lfe_present;
            got.channel_count = header_if.channel_count;
            got.blocks_code   = header_if.blocks_code;
            sb.check_header(got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic pkt_end);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.data_byte   <= b;
        stream_if.packet_last <= pkt_end;
        @(posedge clk);
        while (stream_if.ready !== 1'b1) @(posedge clk);
        sb.note_byte(b, pkt_end);
        bytes_sent++;
    endtask

    // Sync word, header bytes 2 to 6 and byte 7. A packet end at end_at cuts
    // the frame short there.
    task automatic send_frame(input hdr_t h, input logic [7:0] b7, input int end_at);
        logic [63:0] seq;
        int          i;
        seq = {SYNC_FIRST, SYNC_SECOND, h, b7};
        for (i = 0; i < 8; i++) begin
            send_byte(seq[63 - 8 * i -: 8], i == end_at);
            if (i == end_at) break;
        end
    endtask

    function automatic hdr_t ac3_hdr(input logic [4:0] bsid, input logic [1:0] fscod,
                                     input logic [5:0] fsc, input logic [7:0] b6);
        hdr_t h;
        h.b2 = 8'($urandom);
        h.b3 = 8'($urandom);
        h.b4 = {fscod, fsc};
        h.b5 = {bsid, 3'($urandom)};
        h.b6 = b6;
        return h;
    endfunction

    function automatic hdr_t eac3_hdr(input logic [4:0] bsid, input logic [1:0] strmtyp,
                                      input logic [10:0] frmsiz, input logic [7:0] b4);
        hdr_t h;
        h.b2 = {strmtyp, 3'($urandom), frmsiz[10:8]};
        h.b3 = frmsiz[7:0];
        h.b4 = b4;
        h.b5 = {bsid, 3'($urandom)};
        h.b6 = 8'($urandom);
        return h;
    endfunction

    function automatic hdr_t rand_hdr();
        int unsigned k;
        logic [5:0]  fsc;
        logic [10:0] frmsiz;
        k      = $urandom_range(0, 99);
        fsc    = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 37)) : 6'($urandom);
        frmsiz = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 4)) : 11'($urandom);
        if (k < 45)
            return ac3_hdr(5'($urandom_range(0, 10)), 2'($urandom), fsc, 8'($urandom));
        else if (k < 90)
            return eac3_hdr(5'($urandom_range(11, 16)), 2'($urandom), frmsiz, 8'($urandom));
        else
            return ac3_hdr(5'($urandom_range(17, 31)), 2'($urandom), 6'($urandom),
                           8'($urandom));
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned stop;
        int unsigned k;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            k = $urandom_range(0, 99);
            if (k < 72) begin
                send_frame(rand_hdr(), 8'($urandom),
                           ($urandom_range(0, 9) == 0) ? 7 : NO_END);
            end
            else if (k < 80) begin
                send_frame(rand_hdr(), 8'($urandom), $urandom_range(0, 6));
            end
            else if (k < 88) begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), $urandom_range(0, 19) == 0);
            end
            else if (k < 94) begin
                send_byte(SYNC_FIRST, 1'b0);
                send_byte(8'($urandom), 1'b0);
            end
            else begin
                repeat ($urandom_range(1, 3)) send_byte(SYNC_FIRST, 1'b0);
                send_frame(rand_hdr(), 8'($urandom), NO_END);
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        sb          = new();
        bytes_sent  = 0;
        hold_req    = 1'b0;
        tx_idle_pct = 18;
        rx_idle_pct = 77;
        rst_n                 <= 1'b0;
        stream_if.valid       <= 1'b0;
        stream_if.data_byte   <= '0;
        stream_if.packet_last <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // AC-3 path: extremes of rate and size codes, then every channel mode.
        send_frame(ac3_hdr(5'd0, 2'd0, 6'd0, 8'h00), 8'h00, NO_END);
        send_frame(ac3_hdr(5'd8, 2'd2, FSC_MAX, 8'hFF), 8'hFF, NO_END);
        for (i = 0; i < 8; i++)
            send_frame(ac3_hdr((i == 0) ? 5'd10 : 5'(i), 2'(i % 3), 6'(i * 5),
                               {3'(i), 5'($urandom)}), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd9, 2'd1, 6'd21, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd4, FSCOD_RESV, 6'd10, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd6, 2'd1, 6'd38, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd2, 2'd0, 6'd63, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd17, 2'd0, 6'd5, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(ac3_hdr(5'd31, 2'd1, 6'd5, 8'($urandom)), 8'($urandom), NO_END);

        // E-AC-3 path: largest and smallest frames, every stream type and the
        // reduced sample rates.
        send_frame(eac3_hdr(5'd11, 2'd0, 11'h7FF, 8'h00), 8'($urandom), NO_END);
        send_frame(eac3_hdr(5'd16, 2'd1, 11'd3, 8'hFF), 8'($urandom), NO_END);
        send_frame(eac3_hdr(5'd12, 2'd2, 11'd2, 8'($urandom)), 8'($urandom), NO_END);
        send_frame(eac3_hdr(5'd13, FTYPE_RESV, 11'($urandom), 8'($urandom)),
                   8'($urandom), NO_END);
        for (i = 0; i < 3; i++)
            send_frame(eac3_hdr(5'(14 + i % 2), 2'(i), 11'(100 + $urandom_range(0, 1000)),
                                {FSCOD_RESV, 2'(i), 3'($urandom), 1'(i)}),
                       8'($urandom), NO_END);

        // Sync faults: repeated first byte, a lost second byte, a stray second
        // byte, and packet ends at the close, in the middle and on the sync word.
        send_byte(SYNC_FIRST, 1'b0);
        send_byte(SYNC_FIRST, 1'b0);
        send_frame(rand_hdr(), 8'($urandom), NO_END);
        send_byte(SYNC_FIRST, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(SYNC_SECOND, 1'b0);
        send_frame(rand_hdr(), 8'($urandom), 7);
        send_frame(rand_hdr(), 8'($urandom), 4);
        send_frame(rand_hdr(), 8'($urandom), 1);
        send_byte(SYNC_FIRST, 1'b1);
        send_byte(SYNC_SECOND, 1'b0);
        repeat (6) send_byte(8'($urandom), 1'b0);

        run_random(RANDOM_BYTES / 3);

        // Let the output drain completely before the next phase begins.
        stream_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);

        tx_idle_pct = 77;
        rx_idle_pct = 18;
        run_random(RANDOM_BYTES / 3);

        // No idling; the long hold-off at the start fills the block and stalls
        // its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));

        stream_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
